@@ hdl/crtc_pkg.sv @@
// Shared types, register indices, masks and timing constants of the CRT controller.
package crtc_pkg;

    // Transaction opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Bus port select
    localparam logic PORT_INDEX = 1'b0;
    localparam logic PORT_DATA  = 1'b1;

    // Register file geometry
    localparam int unsigned NUM_REGS      = 18;
    localparam int unsigned NUM_WRITABLE  = 16;
    localparam int unsigned CURSOR_ROWS   = 32;

    // Register indices
    localparam logic [4:0] REG_H_TOTAL      = 5'd0;
    localparam logic [4:0] REG_H_DISPLAYED  = 5'd1;
    localparam logic [4:0] REG_HSYNC_POS    = 5'd2;
    localparam logic [4:0] REG_SYNC_WIDTH   = 5'd3;
    localparam logic [4:0] REG_V_TOTAL      = 5'd4;
    localparam logic [4:0] REG_V_ADJUST     = 5'd5;
    localparam logic [4:0] REG_V_DISPLAYED  = 5'd6;
    localparam logic [4:0] REG_VSYNC_POS    = 5'd7;
    localparam logic [4:0] REG_MAX_SCANLINE = 5'd9;
    localparam logic [4:0] REG_CURSOR_START = 5'd10;
    localparam logic [4:0] REG_CURSOR_END   = 5'd11;
    localparam logic [4:0] REG_START_HI     = 5'd12;
    localparam logic [4:0] REG_START_LO     = 5'd13;
    localparam logic [4:0] REG_CURSOR_HI    = 5'd14;
    localparam logic [4:0] REG_CURSOR_LO    = 5'd15;
    localparam logic [4:0] REG_LPEN_HI      = 5'd16;
    localparam logic [4:0] REG_LPEN_LO      = 5'd17;

    localparam logic [7:0] REG_MASK [0:NUM_REGS-1] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h1F, 8'h7F, 8'h7F, 8'h03,
        8'h1F, 8'h7F, 8'h1F, 8'h3F, 8'hFF, 8'h3F, 8'hFF, 8'h00, 8'h00
    };

    // Cursor attribute codes (bits 6:5 of the cursor start register)
    localparam logic [1:0] CUR_ATTR_SOLID = 2'd0;
    localparam logic [1:0] CUR_ATTR_OFF   = 2'd1;
    localparam logic [1:0] CUR_ATTR_FAST  = 2'd2;
    localparam logic [1:0] CUR_ATTR_SLOW  = 2'd3;

    // Cursor mode bits
    localparam int unsigned CM_ENABLED = 0;
    localparam int unsigned CM_BLINK   = 1;
    localparam int unsigned CM_SLOW    = 2;
    localparam logic [2:0]  CM_RESET   = 3'b010;

    // Status flag bits
    localparam int unsigned ST_HS  = 0;
    localparam int unsigned ST_VS  = 1;
    localparam int unsigned ST_HB  = 2;
    localparam int unsigned ST_VB  = 3;
    localparam int unsigned ST_DE  = 4;
    localparam int unsigned ST_HBD = 5;
    localparam int unsigned ST_VBD = 6;
    localparam int unsigned ST_CUR = 7;

    // Frame flag bits
    localparam int unsigned FR_LAST_ROW  = 0;
    localparam int unsigned FR_LAST_LINE = 1;
    localparam int unsigned FR_IN_VTA    = 2;
    localparam int unsigned FR_LAST_VBL  = 3;

    // Timing constants
    localparam logic [7:0] BLINK_FAST       = 8'd8;
    localparam logic [7:0] BLINK_SLOW       = 8'd16;
    localparam logic [7:0] VBLANK_LINES     = 8'd16;
    localparam logic [7:0] UNREADABLE_VALUE = 8'd0;
    localparam logic [7:0] INDEX_READ_VALUE = 8'hFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic       port_sel;
        logic [7:0] data_in;
        logic [7:0] adapter_width;
        logic       adapter_width_valid;
    } crtc_item_t;

    typedef struct packed {
        logic        hsync;
        logic        vsync;
        logic        hblank;
        logic        vblank;
        logic        display_enable;
        logic        hborder;
        logic        vborder;
        logic        cursor;
        logic [15:0] mem_address;
        logic [7:0]  read_data;
    } crtc_result_t;

    // Register view handed from the register file to the timing unit
    typedef struct packed {
        logic [7:0]             h_total;
        logic [7:0]             h_displayed;
        logic [7:0]             hsync_pos;
        logic [7:0]             sync_width;
        logic [6:0]             v_total;
        logic [4:0]             v_adjust;
        logic [6:0]             v_displayed;
        logic [6:0]             vsync_pos;
        logic [4:0]             max_scanline;
        logic [15:0]            start_addr;
        logic [15:0]            cursor_addr;
        logic [CURSOR_ROWS-1:0] cursor_rows;
        logic [2:0]             cursor_mode;
    } crtc_cfg_t;

endpackage

@@ hdl/crtc_regs.sv @@
// Register file, index register, cursor line map and cursor mode of the CRT controller.
module crtc_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic                port_sel,
    input  logic [7:0]          data_in,
    output logic [7:0]          rd_data,
    output crtc_pkg::crtc_cfg_t cfg
);

    logic [7:0]  reg_file_reg [0:crtc_pkg::NUM_WRITABLE-1];
    logic [4:0]  reg_index_reg;
    logic [2:0]  cursor_mode_reg;
    logic [2:0]  cursor_mode_next;
    logic [crtc_pkg::CURSOR_ROWS-1:0] cursor_rows_reg;
    logic [crtc_pkg::CURSOR_ROWS-1:0] cursor_rows_next;

    logic        data_wr;
    logic        index_wr;
    logic [7:0]  wr_value;
    logic [4:0]  r9_new;
    logic [4:0]  start_new;
    logic [4:0]  end_new;
    logic        map_update;

    assign index_wr = wr_en && (port_sel == crtc_pkg::PORT_INDEX) && (data_in <= 8'd17);
    assign data_wr  = wr_en && (port_sel == crtc_pkg::PORT_DATA)
                      && (reg_index_reg < 5'(crtc_pkg::NUM_WRITABLE));
    assign wr_value = data_in & crtc_pkg::REG_MASK[reg_index_reg];

    // Values of R9..R11 as they stand after this write
    always_comb
    begin
        r9_new    = reg_file_reg[crtc_pkg::REG_MAX_SCANLINE[3:0]][4:0];
        start_new = reg_file_reg[crtc_pkg::REG_CURSOR_START[3:0]][4:0];
        end_new   = reg_file_reg[crtc_pkg::REG_CURSOR_END[3:0]][4:0];
        if (data_wr && reg_index_reg == crtc_pkg::REG_MAX_SCANLINE)
        begin
            r9_new = wr_value[4:0];
        end
        if (data_wr && reg_index_reg == crtc_pkg::REG_CURSOR_START)
        begin
            start_new = wr_value[4:0];
        end
        if (data_wr && reg_index_reg == crtc_pkg::REG_CURSOR_END)
        begin
            end_new = wr_value[4:0];
        end
    end

    assign map_update = data_wr && (reg_index_reg == crtc_pkg::REG_MAX_SCANLINE
                                    || reg_index_reg == crtc_pkg::REG_CURSOR_START
                                    || reg_index_reg == crtc_pkg::REG_CURSOR_END);

    // Rebuild the cursor line map from the masked start line, end line and maximum scanline
    always_comb
    begin
        cursor_rows_next = '0;
        if (start_new <= r9_new)
        begin
            for (int i = 0; i < crtc_pkg::CURSOR_ROWS; i++)
            begin
                if (start_new <= end_new)
                begin
                    cursor_rows_next[i] = (5'(i) >= start_new) && (5'(i) <= end_new);
                end
                else
                begin
                    cursor_rows_next[i] = (5'(i) <= end_new) || (5'(i) >= start_new);
                end
            end
        end
    end

    always_comb
    begin
        cursor_mode_next = cursor_mode_reg;
        case (data_in[6:5])
            crtc_pkg::CUR_ATTR_SOLID:
            begin
                cursor_mode_next = cursor_mode_reg;
                cursor_mode_next[crtc_pkg::CM_ENABLED] = 1'b1;
                cursor_mode_next[crtc_pkg::CM_BLINK]   = 1'b0;
            end
            crtc_pkg::CUR_ATTR_OFF:
            begin
                cursor_mode_next = cursor_mode_reg;
                cursor_mode_next[crtc_pkg::CM_ENABLED] = 1'b0;
                cursor_mode_next[crtc_pkg::CM_BLINK]   = 1'b0;
            end
            crtc_pkg::CUR_ATTR_FAST:
            begin
                cursor_mode_next = 3'b011;
            end
            default:
            begin
                cursor_mode_next = 3'b111;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < crtc_pkg::NUM_WRITABLE; i++)
            begin
                reg_file_reg[i] <= 8'd0;
            end
            reg_index_reg   <= 5'd0;
            cursor_mode_reg <= crtc_pkg::CM_RESET;
            cursor_rows_reg <= '0;
        end
        else
        begin
            if (index_wr)
            begin
                reg_index_reg <= data_in[4:0];
            end
            if (data_wr)
            begin
                reg_file_reg[reg_index_reg[3:0]] <= wr_value;
                if (reg_index_reg == crtc_pkg::REG_CURSOR_START)
                begin
                    cursor_mode_reg <= cursor_mode_next;
                end
            end
            if (map_update)
            begin
                cursor_rows_reg <= cursor_rows_next;
            end
        end
    end

    // Bus read: light pen registers are never written and read as zero
    always_comb
    begin
        if (port_sel == crtc_pkg::PORT_INDEX)
        begin
            rd_data = crtc_pkg::INDEX_READ_VALUE;
        end
        else if (reg_index_reg == crtc_pkg::REG_CURSOR_HI
                 || reg_index_reg == crtc_pkg::REG_CURSOR_LO)
        begin
            rd_data = reg_file_reg[reg_index_reg[3:0]];
        end
        else if (reg_index_reg == crtc_pkg::REG_LPEN_HI
                 || reg_index_reg == crtc_pkg::REG_LPEN_LO)
        begin
            rd_data = 8'd0;
        end
        else
        begin
            rd_data = crtc_pkg::UNREADABLE_VALUE;
        end
    end

    always_comb
    begin
        cfg.h_total      = reg_file_reg[crtc_pkg::REG_H_TOTAL[3:0]];
        cfg.h_displayed  = reg_file_reg[crtc_pkg::REG_H_DISPLAYED[3:0]];
        cfg.hsync_pos    = reg_file_reg[crtc_pkg::REG_HSYNC_POS[3:0]];
        cfg.sync_width   = reg_file_reg[crtc_pkg::REG_SYNC_WIDTH[3:0]];
        cfg.v_total      = reg_file_reg[crtc_pkg::REG_V_TOTAL[3:0]][6:0];
        cfg.v_adjust     = reg_file_reg[crtc_pkg::REG_V_ADJUST[3:0]][4:0];
        cfg.v_displayed  = reg_file_reg[crtc_pkg::REG_V_DISPLAYED[3:0]][6:0];
        cfg.vsync_pos    = reg_file_reg[crtc_pkg::REG_VSYNC_POS[3:0]][6:0];
        cfg.max_scanline = reg_file_reg[crtc_pkg::REG_MAX_SCANLINE[3:0]][4:0];
        cfg.start_addr   = {reg_file_reg[crtc_pkg::REG_START_HI[3:0]],
                            reg_file_reg[crtc_pkg::REG_START_LO[3:0]]};
        cfg.cursor_addr  = {reg_file_reg[crtc_pkg::REG_CURSOR_HI[3:0]],
                            reg_file_reg[crtc_pkg::REG_CURSOR_LO[3:0]]};
        cfg.cursor_rows  = cursor_rows_reg;
        cfg.cursor_mode  = cursor_mode_reg;
    end

endmodule

@@ hdl/crtc_timing.sv @@
// Character, scanline, row, adjust, sync and blink counters with the status flags.
module crtc_timing (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_en,
    input  logic [7:0]          eff_width,
    input  crtc_pkg::crtc_cfg_t cfg,
    output logic [7:0]          status,
    output logic [15:0]         address
);

    logic [7:0]  cc_reg,   cc_next;
    logic [7:0]  rc_reg,   rc_next;
    logic [4:0]  sc_reg,   sc_next;
    logic [4:0]  adj_reg,  adj_next;
    logic [7:0]  hsc_reg,  hsc_next;
    logic [7:0]  vsc_reg,  vsc_next;
    logic [7:0]  hst_reg,  hst_next;
    logic [15:0] addr_reg, addr_next;
    logic [15:0] rsa_reg,  rsa_next;
    logic [15:0] fsl_reg,  fsl_next;
    logic [7:0]  bc_reg,   bc_next;
    logic        bp_reg,   bp_next;
    logic [7:0]  st_reg,   st_next;
    logic [3:0]  fr_reg,   fr_next;

    logic [8:0]  line_end;
    logic [5:0]  row_end;
    logic [7:0]  blink_rate;
    logic        cur_on;

    assign line_end   = {1'b0, cfg.h_total} + 9'd1;
    assign row_end    = {1'b0, cfg.max_scanline} + 6'd1;
    assign blink_rate = cfg.cursor_mode[crtc_pkg::CM_SLOW] ? crtc_pkg::BLINK_SLOW
                                                            : crtc_pkg::BLINK_FAST;

    always_comb
    begin
        cc_next   = cc_reg;
        rc_next   = rc_reg;
        sc_next   = sc_reg;
        adj_next  = adj_reg;
        hsc_next  = hsc_reg;
        vsc_next  = vsc_reg;
        hst_next  = hst_reg;
        addr_next = addr_reg;
        rsa_next  = rsa_reg;
        fsl_next  = fsl_reg;
        bc_next   = bc_reg;
        bp_next   = bp_reg;
        st_next   = st_reg;
        fr_next   = fr_reg;
        cur_on    = 1'b0;

        if (tick_en)
        begin
            st_next[crtc_pkg::ST_HS] = 1'b0;
            st_next[crtc_pkg::ST_VS] = 1'b0;

            if (cc_reg == 8'd0)
            begin
                st_next[crtc_pkg::ST_HBD] = 1'b0;
                if (rc_reg == 8'd0)
                begin
                    addr_next = fsl_reg;
                end
            end
            if (cc_reg < 8'd2 && rc_reg == {1'b0, cfg.v_total})
            begin
                fr_next[crtc_pkg::FR_LAST_ROW]  = 1'b1;
                fr_next[crtc_pkg::FR_LAST_LINE] = (sc_reg == cfg.max_scanline);
                adj_next = 5'd0;
            end

            cc_next   = cc_reg + 8'd1;
            addr_next = addr_next + 16'd1;

            // Horizontal blanking: count towards the sync target and the blank end
            if (st_next[crtc_pkg::ST_HB])
            begin
                hsc_next = hsc_reg + 8'd1;
                hst_next = (eff_width < cfg.sync_width) ? eff_width : cfg.sync_width;
                if (hsc_next == hst_next)
                begin
                    if (st_next[crtc_pkg::ST_VB] && vsc_reg == crtc_pkg::VBLANK_LINES)
                    begin
                        fr_next[crtc_pkg::FR_LAST_VBL] = 1'b1;
                        vsc_next = 8'd0;
                        st_next[crtc_pkg::ST_VS] = 1'b1;
                    end
                    st_next[crtc_pkg::ST_HS] = 1'b1;
                end
                if (hsc_next == cfg.sync_width)
                begin
                    st_next[crtc_pkg::ST_HB] = 1'b0;
                    hsc_next = 8'd0;
                end
            end

            if (cc_next == cfg.h_displayed)
            begin
                if (sc_reg == cfg.max_scanline)
                begin
                    rsa_next = addr_next;
                end
                st_next[crtc_pkg::ST_DE]  = 1'b0;
                st_next[crtc_pkg::ST_HBD] = 1'b1;
            end

            if (cc_next == cfg.hsync_pos)
            begin
                hst_next = eff_width;
                st_next[crtc_pkg::ST_HB] = 1'b1;
                hsc_next = 8'd0;
            end

            // End of scanline
            if ({1'b0, cc_next} == line_end)
            begin
                if (fr_next[crtc_pkg::FR_LAST_VBL])
                begin
                    st_next[crtc_pkg::ST_HBD] = 1'b1;
                end
                if (st_next[crtc_pkg::ST_VB])
                begin
                    vsc_next = vsc_next + 8'd1;
                end
                if (fr_next[crtc_pkg::FR_LAST_VBL])
                begin
                    fr_next[crtc_pkg::FR_LAST_VBL] = 1'b0;
                    st_next[crtc_pkg::ST_VB] = 1'b0;
                end
                cc_next = 8'd0;
                st_next[crtc_pkg::ST_HBD] = 1'b0;
                sc_next   = sc_reg + 5'd1;
                addr_next = rsa_next;

                if (!st_next[crtc_pkg::ST_VB] && rc_reg < {1'b0, cfg.v_displayed})
                begin
                    st_next[crtc_pkg::ST_DE]  = 1'b1;
                    st_next[crtc_pkg::ST_HBD] = 1'b0;
                end

                // End of character row
                if ({1'b0, sc_next} == row_end)
                begin
                    sc_next   = 5'd0;
                    rc_next   = rc_reg + 8'd1;
                    addr_next = rsa_next;
                    if (rc_next == {1'b0, cfg.vsync_pos})
                    begin
                        st_next[crtc_pkg::ST_VB] = 1'b1;
                        st_next[crtc_pkg::ST_DE] = 1'b0;
                        if (cfg.cursor_mode[crtc_pkg::CM_BLINK])
                        begin
                            bc_next = bc_reg + 8'd1;
                            if (bc_next == blink_rate)
                            begin
                                bc_next = 8'd0;
                                bp_next = ~bp_reg;
                            end
                        end
                    end
                    if (fr_next[crtc_pkg::FR_LAST_LINE])
                    begin
                        fr_next[crtc_pkg::FR_IN_VTA]    = 1'b1;
                        fr_next[crtc_pkg::FR_LAST_ROW]  = 1'b0;
                        fr_next[crtc_pkg::FR_LAST_LINE] = 1'b0;
                    end
                end

                if (rc_next == {1'b0, cfg.v_displayed})
                begin
                    st_next[crtc_pkg::ST_DE]  = 1'b0;
                    st_next[crtc_pkg::ST_VBD] = 1'b1;
                end

                // Vertical total adjust: restart the frame once it runs out
                if (fr_next[crtc_pkg::FR_IN_VTA])
                begin
                    if (adj_next == cfg.v_adjust)
                    begin
                        fr_next[crtc_pkg::FR_IN_VTA] = 1'b0;
                        adj_next  = 5'd0;
                        cc_next   = 8'd0;
                        rc_next   = 8'd0;
                        sc_next   = 5'd0;
                        fsl_next  = cfg.start_addr;
                        addr_next = cfg.start_addr;
                        rsa_next  = cfg.start_addr;
                        st_next[crtc_pkg::ST_DE]  = 1'b1;
                        st_next[crtc_pkg::ST_VBD] = 1'b0;
                        st_next[crtc_pkg::ST_VB]  = 1'b0;
                    end
                    else
                    begin
                        adj_next = adj_next + 5'd1;
                    end
                end
            end

            cur_on = cfg.cursor_mode[crtc_pkg::CM_ENABLED]
                     && (addr_next == cfg.cursor_addr)
                     && cfg.cursor_rows[sc_next]
                     && (!cfg.cursor_mode[crtc_pkg::CM_BLINK] || bp_next);
            st_next[crtc_pkg::ST_CUR] = cur_on;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg   <= 8'd0;
            rc_reg   <= 8'd0;
            sc_reg   <= 5'd0;
            adj_reg  <= 5'd0;
            hsc_reg  <= 8'd0;
            vsc_reg  <= 8'd0;
            hst_reg  <= 8'd0;
            addr_reg <= 16'd0;
            rsa_reg  <= 16'd0;
            fsl_reg  <= 16'd0;
            bc_reg   <= 8'd0;
            bp_reg   <= 1'b0;
            st_reg   <= 8'd0;
            fr_reg   <= 4'd0;
        end
        else
        begin
            cc_reg   <= cc_next;
            rc_reg   <= rc_next;
            sc_reg   <= sc_next;
            adj_reg  <= adj_next;
            hsc_reg  <= hsc_next;
            vsc_reg  <= vsc_next;
            hst_reg  <= hst_next;
            addr_reg <= addr_next;
            rsa_reg  <= rsa_next;
            fsl_reg  <= fsl_next;
            bc_reg   <= bc_next;
            bp_reg   <= bp_next;
            st_reg   <= st_next;
            fr_reg   <= fr_next;
        end
    end

    // Flags and address as they stand after this transaction
    assign status  = st_next;
    assign address = addr_next;

endmodule

@@ hdl/crt_controller_timing.sv @@
// Top level of the CRT controller: input and result registers around the timing core.
//
// Usage: each transaction on the item channel is a character tick, a bus write
// (index or data port) or a bus read. Every item yields exactly one result on
// the result channel with the sync, blanking, display, border and cursor flags,
// the video memory address and, for reads, the register data.
// Both channels use valid/stall; a transaction completes on a rising edge with
// valid high and stall low.
// Path: a taken item waits in the input register, and the step logic loads its result
// into the result register whenever that register is free or being taken.
// Throughput: one item per cycle while result_stall is low; the step logic between
// the input register and the result register settles the whole tick combinationally.
// Stall: while a result is held by result_stall the input register keeps its
// item and item_stall rises once it is full; nothing is dropped.
// Reset: rst_n clears the register file, index and counters to zero, the cursor mode to
// disabled with blink set at the fast rate, and empties both stages.
module crt_controller_timing (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  crtc_pkg::crtc_item_t   item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output crtc_pkg::crtc_result_t result
);

    logic                   in_valid_reg;
    crtc_pkg::crtc_item_t   in_item_reg;
    logic                   out_valid_reg;
    crtc_pkg::crtc_result_t out_result_reg;
    crtc_pkg::crtc_result_t out_result_next;

    logic                   advance;
    logic                   process;
    logic                   tick_en;
    logic                   wr_en;
    logic [7:0]             eff_width;
    logic [7:0]             rd_data;
    logic [7:0]             status;
    logic [15:0]            address;
    crtc_pkg::crtc_cfg_t    cfg;

    // Advance the pipeline whenever the result register is free or being taken
    assign advance    = !(out_valid_reg && result_stall);
    assign process    = in_valid_reg && advance;
    assign item_stall = in_valid_reg && !advance;

    assign tick_en   = process && (in_item_reg.opcode == crtc_pkg::OP_TICK);
    assign wr_en     = process && (in_item_reg.opcode == crtc_pkg::OP_WRITE);
    assign eff_width = in_item_reg.adapter_width_valid ? in_item_reg.adapter_width
                                                       : cfg.sync_width;

    crtc_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .port_sel (in_item_reg.port_sel),
        .data_in  (in_item_reg.data_in),
        .rd_data  (rd_data),
        .cfg      (cfg)
    );

    crtc_timing u_timing (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick_en   (tick_en),
        .eff_width (eff_width),
        .cfg       (cfg),
        .status    (status),
        .address   (address)
    );

    // Assemble the result; bus transactions report the flags held from the last tick
    always_comb
    begin
        out_result_next.hsync          = status[crtc_pkg::ST_HS];
        out_result_next.vsync          = status[crtc_pkg::ST_VS];
        out_result_next.hblank         = status[crtc_pkg::ST_HB];
        out_result_next.vblank         = status[crtc_pkg::ST_VB];
        out_result_next.display_enable = status[crtc_pkg::ST_DE];
        out_result_next.hborder        = status[crtc_pkg::ST_HBD];
        out_result_next.vborder        = status[crtc_pkg::ST_VBD];
        out_result_next.cursor         = status[crtc_pkg::ST_CUR];
        out_result_next.mem_address    = address;
        out_result_next.read_data      = (in_item_reg.opcode == crtc_pkg::OP_READ) ? rd_data
                                                                                   : 8'd0;
    end

    // Input register: hold the item while the result side stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!item_stall)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_result_reg <= out_result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_result_reg;

`ifndef SYNTHESIS
    // Vertical sync only fires together with horizontal sync
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.vsync || result.hsync))
    else $error("vsync reported without hsync");

    // Display enable is never active inside vertical blanking
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.display_enable && result.vblank))
    else $error("display enable during vertical blanking");

    // A new result only follows an item held in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
    else $error("result raised without a held item");

    // A stalled full input register holds its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && result_stall) |=> in_valid_reg)
    else $error("held item dropped while result stalled");
`endif

endmodule
